@@ src/pce_pkg.sv @@
// Shared widths, codes and types of the piecewise cubic evaluator.
// No dependencies; all other files but pce_ram refer to it by scoped names.
`default_nettype none

package pce_pkg;

  // Field widths of the request, result and configuration channels.
  localparam int REQ_W     = 1;
  localparam int IDX_W     = 7;
  localparam int X_W       = 24;
  localparam int C_W       = 32;
  localparam int Y_W       = 32;
  localparam int SEG_HIT_W = 6;
  localparam int CNT_W     = 7;

  // Internal arithmetic widths: Horner accumulator and raw product.
  localparam int ACC_W  = 40;
  localparam int PROD_W = 64;

  // Segment search works on groups of this many hit bits.
  localparam int GRP_SIZE  = 8;
  localparam int GRP_IDX_W = 3;

  localparam logic [CNT_W-1:0] CNT_RESET = 7'd2;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_LOAD = 1'b0;
  localparam logic [REQ_W-1:0] REQ_EVAL = 1'b1;

  // Saturation limits, kept in the width they are compared at.
  localparam logic signed [PROD_W-1:0] ACC_MAX = 64'sd549755813887;
  localparam logic signed [PROD_W-1:0] ACC_MIN = -64'sd549755813888;
  localparam logic signed [ACC_W-1:0]  VAL_MAX = 40'sd2147483647;
  localparam logic signed [ACC_W-1:0]  VAL_MIN = -40'sd2147483648;

  typedef struct packed {
    logic signed [C_W-1:0] cubic;
    logic signed [C_W-1:0] square;
    logic signed [C_W-1:0] linear;
    logic signed [C_W-1:0] offset;
  } coef_t;

endpackage

`default_nettype wire

@@ src/pce_if.sv @@
// Handshake channels of the piecewise cubic evaluator: request, result, configuration.
// Depends on pce_pkg for the field widths.
`default_nettype none

interface pce_req_if;
  logic                                 valid;
  logic                                 ready;
  logic        [pce_pkg::REQ_W-1:0]     req_type;
  logic        [pce_pkg::IDX_W-1:0]     entry_index;
  logic signed [pce_pkg::X_W-1:0]       knot_x;
  logic signed [pce_pkg::C_W-1:0]       coef_cubic;
  logic signed [pce_pkg::C_W-1:0]       coef_square;
  logic signed [pce_pkg::C_W-1:0]       coef_linear;
  logic signed [pce_pkg::C_W-1:0]       coef_const;
  logic signed [pce_pkg::X_W-1:0]       query_x;

  modport source (
    output valid, req_type, entry_index, knot_x, coef_cubic, coef_square,
           coef_linear, coef_const, query_x,
    input  ready
  );
  modport sink (
    input  valid, req_type, entry_index, knot_x, coef_cubic, coef_square,
           coef_linear, coef_const, query_x,
    output ready
  );
endinterface

interface pce_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [pce_pkg::Y_W-1:0]       value_y;
  logic                                 in_range;
  logic        [pce_pkg::SEG_HIT_W-1:0] segment_hit;

  modport source (output valid, value_y, in_range, segment_hit, input ready);
  modport sink   (input valid, value_y, in_range, segment_hit, output ready);
endinterface

interface pce_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pce_pkg::CNT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ src/pce_ram.sv @@
// Generic single-port RAM with registered read, used for the coefficient tables.
// No dependencies.
`default_nettype none

module pce_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire               clk_i,
  input  wire               en_i,
  input  wire               we_i,
  input  wire [ADDR_W-1:0]  addr_i,
  input  wire [WIDTH-1:0]   wdata_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ src/pce_horner_step.sv @@
// One Horner step t' = sat40(round(t * q) + coef), as a multiply stage and an add stage.
// Depends on pce_pkg for widths and saturation limits.
`default_nettype none

module pce_horner_step #(
  parameter int X_FRAC_BITS = 16
) (
  input  wire                                   clk_i,
  input  wire                                   en_i,
  input  wire logic signed [pce_pkg::ACC_W-1:0] t_i,
  input  wire logic signed [pce_pkg::X_W-1:0]   q_i,
  input  wire logic signed [pce_pkg::C_W-1:0]   coef_i,
  output logic signed [pce_pkg::ACC_W-1:0]      t_o,
  output logic signed [pce_pkg::X_W-1:0]        q_o
);

  localparam logic signed [pce_pkg::PROD_W-1:0] Half = 64'sd1 <<< (X_FRAC_BITS - 1);

  logic signed [pce_pkg::PROD_W-1:0] prod_d, prod_q;
  logic signed [pce_pkg::C_W-1:0]    coef_q;
  logic signed [pce_pkg::X_W-1:0]    qm_q, qa_q;
  logic signed [pce_pkg::PROD_W-1:0] rnd, sum;
  logic signed [pce_pkg::ACC_W-1:0]  t_d, t_q;

  // Exact product, at most 63 significant bits.
  assign prod_d = t_i * q_i;

  always_comb begin
    rnd = (prod_q + Half) >>> X_FRAC_BITS;
    sum = rnd + pce_pkg::PROD_W'(coef_q);
    if (sum > pce_pkg::ACC_MAX) begin
      t_d = pce_pkg::ACC_MAX[pce_pkg::ACC_W-1:0];
    end else if (sum < pce_pkg::ACC_MIN) begin
      t_d = pce_pkg::ACC_MIN[pce_pkg::ACC_W-1:0];
    end else begin
      t_d = sum[pce_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      coef_q <= coef_i;
      qm_q   <= q_i;
      t_q    <= t_d;
      qa_q   <= qm_q;
    end
  end

  assign t_o = t_q;
  assign q_o = qa_q;

endmodule

`default_nettype wire

@@ src/piecewise_cubic_evaluator.sv @@
// Piecewise cubic evaluator: top level with knot search, coefficient tables and Horner pipeline.
// Depends on pce_pkg, pce_if, pce_ram and pce_horner_step.
//
// Takes one item per clock while no result is held, and returns the result of each evaluate
// item in order; load items pass down the same pipe and give no result. Knots sit in
// registers and are compared against the query all at once; the first segment that holds
// the query is found by a two-level registered search (groups of eight, then across
// groups), its coefficients come from four single-port RAMs, and three Horner steps of a
// multiply stage and an add stage each follow. The whole pipe holds while a result waits
// to be taken. A load writes its knot at the compare stage and its coefficients at the
// RAM stage, so every item sees exactly the loads accepted before it. Tables are not
// cleared at reset: load every knot and segment before evaluating.
`default_nettype none

module piecewise_cubic_evaluator #(
  parameter int MAX_SEGMENTS = 64,
  parameter int X_FRAC_BITS  = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  pce_cfg_if.sink    cfg_i,
  pce_req_if.sink    req_i,
  pce_rsp_if.source  rsp_o
);

  localparam int KNOTS     = MAX_SEGMENTS + 1;
  localparam int KNOT_REGS = (KNOTS < 2 ** pce_pkg::IDX_W) ? KNOTS : 2 ** pce_pkg::IDX_W;
  localparam int SEG_W     = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int GRPS      = (MAX_SEGMENTS + pce_pkg::GRP_SIZE - 1) / pce_pkg::GRP_SIZE;
  localparam int HIT_W     = GRPS * pce_pkg::GRP_SIZE;

  logic adv;
  logic [pce_pkg::CNT_W-1:0] cnt_q;

  // Stage 0: input register.
  logic                           s0_vld_q;
  logic [pce_pkg::REQ_W-1:0]      s0_type_q;
  logic [pce_pkg::IDX_W-1:0]      s0_idx_q;
  logic signed [pce_pkg::X_W-1:0] s0_knot_q, s0_x_q;
  pce_pkg::coef_t                 s0_coef_q;

  // Stage 1: knot compares.
  logic                           s1_vld_q;
  logic [pce_pkg::REQ_W-1:0]      s1_type_q;
  logic [pce_pkg::IDX_W-1:0]      s1_idx_q;
  logic signed [pce_pkg::X_W-1:0] s1_x_q;
  pce_pkg::coef_t                 s1_coef_q;
  logic [KNOTS-1:0]               ge_d, s1_ge_q;

  // Stage 2: per-group first hit.
  logic                           s2_vld_q;
  logic [pce_pkg::REQ_W-1:0]      s2_type_q;
  logic [pce_pkg::IDX_W-1:0]      s2_idx_q;
  logic signed [pce_pkg::X_W-1:0] s2_x_q;
  pce_pkg::coef_t                 s2_coef_q;
  logic [HIT_W-1:0]               hit;
  logic [GRPS-1:0]                any_d, s2_any_q;
  logic [pce_pkg::GRP_IDX_W-1:0]  gidx_d [GRPS];
  logic [pce_pkg::GRP_IDX_W-1:0]  s2_gidx_q [GRPS];

  // Stage 3: segment picked, RAM access.
  logic                           s3_vld_q;
  logic [pce_pkg::REQ_W-1:0]      s3_type_q;
  logic [pce_pkg::IDX_W-1:0]      s3_idx_q;
  logic signed [pce_pkg::X_W-1:0] s3_x_q;
  pce_pkg::coef_t                 s3_coef_q;
  logic [SEG_W-1:0]               seg_d, s3_seg_q;
  logic                           hit_d, s3_hit_q;

  // Stages 4 to 10: evaluate items only.
  logic [10:4]                    ev_vld_q;
  logic [10:4]                    ev_hit_q;
  logic [SEG_W-1:0]               ev_seg_q [4:10];
  logic signed [pce_pkg::X_W-1:0] s4_x_q;
  logic signed [pce_pkg::C_W-1:0] lin_q [5:6];
  logic signed [pce_pkg::C_W-1:0] off_q [5:8];

  logic                           ram_we;
  logic [SEG_W-1:0]               ram_addr;
  logic [pce_pkg::C_W-1:0]        rd_cubic, rd_square, rd_linear, rd_offset;

  logic signed [pce_pkg::ACC_W-1:0] t1, t2, t3;
  logic signed [pce_pkg::X_W-1:0]   q1, q2, q3;

  logic                               rsp_vld_q;
  logic signed [pce_pkg::Y_W-1:0]     y_d, y_q;
  logic                               rng_q;
  logic [pce_pkg::SEG_HIT_W-1:0]      seg_out_q;

  logic signed [pce_pkg::X_W-1:0] knot_q [KNOT_REGS];
  logic                           knot_we;

  // Whole pipe moves unless a finished result is held.
  assign adv         = !rsp_vld_q || rsp_o.ready;
  assign req_i.ready = adv;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= pce_pkg::CNT_RESET;
    end else if (cfg_i.valid) begin
      cnt_q <= cfg_i.data;
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q  <= 1'b0;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      ev_vld_q  <= '0;
      rsp_vld_q <= 1'b0;
    end else if (adv) begin
      s0_vld_q  <= req_i.valid;
      s1_vld_q  <= s0_vld_q;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      ev_vld_q  <= {ev_vld_q[9:4], s3_vld_q && (s3_type_q == pce_pkg::REQ_EVAL)};
      rsp_vld_q <= ev_vld_q[10];
    end
  end

  // Knot registers, written as a load leaves stage 0.
  assign knot_we = adv && s0_vld_q && (s0_type_q == pce_pkg::REQ_LOAD);

  for (genvar e = 0; e < KNOTS; e++) begin : g_knot
    if (e < KNOT_REGS) begin : g_live
      always_ff @(posedge clk_i) begin
        if (knot_we && (s0_idx_q == pce_pkg::IDX_W'(e))) begin
          knot_q[e] <= s0_knot_q;
        end
      end
      assign ge_d[e] = s0_x_q >= knot_q[e];
    end else begin : g_none
      // a 7-bit index never reaches this knot
      assign ge_d[e] = 1'b0;
    end
  end

  // A segment holds the query when its left knot is <= q, its right knot is > q and it lies below the segment count.
  for (genvar i = 0; i < HIT_W; i++) begin : g_hit
    if (i < MAX_SEGMENTS) begin : g_live
      assign hit[i] = s1_ge_q[i] && !s1_ge_q[i+1] && (int'(cnt_q) > i);
    end else begin : g_pad
      assign hit[i] = 1'b0;
    end
  end

  always_comb begin
    for (int g = 0; g < GRPS; g++) begin
      any_d[g]  = |hit[g*pce_pkg::GRP_SIZE +: pce_pkg::GRP_SIZE];
      gidx_d[g] = '0;
      for (int k = pce_pkg::GRP_SIZE - 1; k >= 0; k--) begin
        if (hit[g*pce_pkg::GRP_SIZE + k]) begin
          gidx_d[g] = pce_pkg::GRP_IDX_W'(k);
        end
      end
    end
  end

  always_comb begin
    seg_d = '0;
    hit_d = 1'b0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (s2_any_q[g]) begin
        hit_d = 1'b1;
        seg_d = SEG_W'(g * pce_pkg::GRP_SIZE + int'(s2_gidx_q[g]));
      end
    end
  end

  // Payload of stages 0 to 3.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_type_q <= req_i.req_type;
      s0_idx_q  <= req_i.entry_index;
      s0_knot_q <= req_i.knot_x;
      s0_x_q    <= req_i.query_x;
      s0_coef_q <= '{cubic:  req_i.coef_cubic,  square: req_i.coef_square,
                     linear: req_i.coef_linear, offset: req_i.coef_const};

      s1_type_q <= s0_type_q;
      s1_idx_q  <= s0_idx_q;
      s1_x_q    <= s0_x_q;
      s1_coef_q <= s0_coef_q;
      s1_ge_q   <= ge_d;

      s2_type_q <= s1_type_q;
      s2_idx_q  <= s1_idx_q;
      s2_x_q    <= s1_x_q;
      s2_coef_q <= s1_coef_q;
      s2_any_q  <= any_d;
      s2_gidx_q <= gidx_d;

      s3_type_q <= s2_type_q;
      s3_idx_q  <= s2_idx_q;
      s3_x_q    <= s2_x_q;
      s3_coef_q <= s2_coef_q;
      s3_seg_q  <= seg_d;
      s3_hit_q  <= hit_d;
    end
  end

  // Coefficient tables: a load writes only below the segment count.
  assign ram_we = s3_vld_q && (s3_type_q == pce_pkg::REQ_LOAD) && (s3_idx_q < cnt_q)
                  && (int'(s3_idx_q) < MAX_SEGMENTS);
  assign ram_addr = ram_we ? SEG_W'(s3_idx_q) : s3_seg_q;

  pce_ram #(.WIDTH(pce_pkg::C_W), .DEPTH(MAX_SEGMENTS)) u_ram_cubic (
    .clk_i, .en_i(adv), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(s3_coef_q.cubic), .rdata_o(rd_cubic)
  );
  pce_ram #(.WIDTH(pce_pkg::C_W), .DEPTH(MAX_SEGMENTS)) u_ram_square (
    .clk_i, .en_i(adv), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(s3_coef_q.square), .rdata_o(rd_square)
  );
  pce_ram #(.WIDTH(pce_pkg::C_W), .DEPTH(MAX_SEGMENTS)) u_ram_linear (
    .clk_i, .en_i(adv), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(s3_coef_q.linear), .rdata_o(rd_linear)
  );
  pce_ram #(.WIDTH(pce_pkg::C_W), .DEPTH(MAX_SEGMENTS)) u_ram_offset (
    .clk_i, .en_i(adv), .we_i(ram_we), .addr_i(ram_addr),
    .wdata_i(s3_coef_q.offset), .rdata_o(rd_offset)
  );

  // Side data that rides along the Horner steps.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_x_q      <= s3_x_q;
      ev_hit_q    <= {ev_hit_q[9:4], s3_hit_q};
      ev_seg_q[4] <= s3_seg_q;
      for (int k = 5; k <= 10; k++) begin
        ev_seg_q[k] <= ev_seg_q[k-1];
      end
      lin_q[5] <= $signed(rd_linear);
      lin_q[6] <= lin_q[5];
      off_q[5] <= $signed(rd_offset);
      for (int k = 6; k <= 8; k++) begin
        off_q[k] <= off_q[k-1];
      end
    end
  end

  pce_horner_step #(.X_FRAC_BITS(X_FRAC_BITS)) u_step_1 (
    .clk_i, .en_i(adv),
    .t_i(pce_pkg::ACC_W'($signed(rd_cubic))), .q_i(s4_x_q), .coef_i($signed(rd_square)),
    .t_o(t1), .q_o(q1)
  );
  pce_horner_step #(.X_FRAC_BITS(X_FRAC_BITS)) u_step_2 (
    .clk_i, .en_i(adv), .t_i(t1), .q_i(q1), .coef_i(lin_q[6]), .t_o(t2), .q_o(q2)
  );
  pce_horner_step #(.X_FRAC_BITS(X_FRAC_BITS)) u_step_3 (
    .clk_i, .en_i(adv), .t_i(t2), .q_i(q2), .coef_i(off_q[8]), .t_o(t3), .q_o(q3)
  );

  // Output register: saturate to 32 bits, zero on a miss.
  always_comb begin
    if (!ev_hit_q[10]) begin
      y_d = '0;
    end else if (t3 > pce_pkg::VAL_MAX) begin
      y_d = pce_pkg::VAL_MAX[pce_pkg::Y_W-1:0];
    end else if (t3 < pce_pkg::VAL_MIN) begin
      y_d = pce_pkg::VAL_MIN[pce_pkg::Y_W-1:0];
    end else begin
      y_d = t3[pce_pkg::Y_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      y_q       <= y_d;
      rng_q     <= ev_hit_q[10];
      seg_out_q <= ev_hit_q[10] ? pce_pkg::SEG_HIT_W'(ev_seg_q[10]) : '0;
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.value_y     = y_q;
  assign rsp_o.in_range    = rng_q;
  assign rsp_o.segment_hit = seg_out_q;

`ifndef SYNTH
  a_hit_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_vld_q && (s3_type_q == pce_pkg::REQ_EVAL) && s3_hit_q |->
      int'(s3_seg_q) < int'(cnt_q))
    else $error("segment hit at or above the segment count");

  a_stall_on_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rsp_o.valid && !rsp_o.ready)
    else $error("input stalled without a held result");

  a_load_gives_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && s3_vld_q && (s3_type_q == pce_pkg::REQ_LOAD) |=> !ev_vld_q[4])
    else $error("load item entered the evaluate pipe");

  a_miss_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.in_range |-> (rsp_o.value_y == '0) && (rsp_o.segment_hit == '0))
    else $error("out of range result is not zero");
`endif

  // q3 leaves the last step unused beyond here; fold it into nothing observable
  logic unused_q3;
  assign unused_q3 = ^q3;

endmodule

`default_nettype wire

@@ tb/sv/pce_tb_pkg.sv @@
`timescale 1ns / 100ps
// Request/result item types and the spline table tracker used by the evaluator testbench.
// Depends on pce_pkg for field widths, request codes and saturation limits.

package pce_tb_pkg;

  localparam int SEG_MAX = 64;
  localparam int XFRAC   = 16;

  typedef struct {
    logic        [pce_pkg::REQ_W-1:0] req_type;
    logic        [pce_pkg::IDX_W-1:0] entry_index;
    logic signed [pce_pkg::X_W-1:0]   knot_x;
    logic signed [pce_pkg::C_W-1:0]   coef_cubic;
    logic signed [pce_pkg::C_W-1:0]   coef_square;
    logic signed [pce_pkg::C_W-1:0]   coef_linear;
    logic signed [pce_pkg::C_W-1:0]   coef_const;
    logic signed [pce_pkg::X_W-1:0]   query_x;
  } pce_request_t;

  typedef struct {
    logic signed [pce_pkg::Y_W-1:0]       value_y;
    logic                                 in_range;
    logic        [pce_pkg::SEG_HIT_W-1:0] segment_hit;
  } pce_point_t;

  // Mirrors the knot/coefficient tables and queues the curve points still owed.
  class spline_table_model;
    int unsigned                      mismatches;
    int unsigned                      points_seen;
    logic        [pce_pkg::CNT_W-1:0] seg_count;
    logic signed [pce_pkg::X_W-1:0]   knots  [0:SEG_MAX];
    logic signed [pce_pkg::C_W-1:0]   cubic  [0:SEG_MAX-1];
    logic signed [pce_pkg::C_W-1:0]   square [0:SEG_MAX-1];
    logic signed [pce_pkg::C_W-1:0]   linear [0:SEG_MAX-1];
    logic signed [pce_pkg::C_W-1:0]   offset [0:SEG_MAX-1];
    pce_point_t                       awaited_points[$];

    function new();
      mismatches  = 0;
      points_seen = 0;
      seg_count   = pce_pkg::CNT_RESET;
      foreach (knots[i]) knots[i] = '0;
      foreach (cubic[i]) begin
        cubic[i]  = '0;
        square[i] = '0;
        linear[i] = '0;
        offset[i] = '0;
      end
    endfunction

    function int active_segments();
      return (seg_count > SEG_MAX) ? SEG_MAX : int'(seg_count);
    endfunction

    function void set_segment_count(logic [pce_pkg::CNT_W-1:0] v);
      seg_count = v;
    endfunction

    function int pending();
      return awaited_points.size();
    endfunction

    // One Horner step: acc*q rounded half up to Q24.16, plus coef, clamped to 40 bits.
    function longint horner_step(longint acc, longint q, longint coef);
      longint t;
      t = ((acc * q + (64'sd1 <<< (XFRAC - 1))) >>> XFRAC) + coef;
      if (t > pce_pkg::ACC_MAX) t = pce_pkg::ACC_MAX;
      if (t < pce_pkg::ACC_MIN) t = pce_pkg::ACC_MIN;
      return t;
    endfunction

    function void note_request(pce_request_t r);
      int         n;
      int         idx;
      bit         found;
      longint     q;
      longint     acc;
      pce_point_t pt;
      n = active_segments();
      if (r.req_type == pce_pkg::REQ_LOAD) begin
        idx = int'(r.entry_index);
        if (idx <= SEG_MAX) begin
          knots[idx] = r.knot_x;
          if (idx < n) begin
            cubic[idx]  = r.coef_cubic;
            square[idx] = r.coef_square;
            linear[idx] = r.coef_linear;
            offset[idx] = r.coef_const;
          end
        end
        return;
      end
      q = r.query_x;
      found = 0;
      pt.value_y = '0;
      pt.in_range = 1'b0;
      pt.segment_hit = '0;
      for (int i = 0; i < n; i++) begin
        if (!found && knots[i] <= q && q < knots[i+1]) begin
          found = 1;
          acc = cubic[i];
          acc = horner_step(acc, q, square[i]);
          acc = horner_step(acc, q, linear[i]);
          acc = horner_step(acc, q, offset[i]);
          if (acc > pce_pkg::VAL_MAX) acc = pce_pkg::VAL_MAX;
          if (acc < pce_pkg::VAL_MIN) acc = pce_pkg::VAL_MIN;
          pt.value_y = acc[pce_pkg::Y_W-1:0];
          pt.in_range = 1'b1;
          pt.segment_hit = i[pce_pkg::SEG_HIT_W-1:0];
        end
      end
      awaited_points.push_back(pt);
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("MISMATCH point %0d: %s", points_seen, msg);
    endtask

    task check_point(pce_point_t got);
      pce_point_t want;
      points_seen++;
      if (awaited_points.size() == 0) begin
        report_mismatch("result with no evaluate item outstanding");
        return;
      end
      want = awaited_points.pop_front();
      if (got.value_y !== want.value_y)
        report_mismatch($sformatf("value_y %h, want %h", got.value_y, want.value_y));
      if (got.in_range !== want.in_range)
        report_mismatch($sformatf("in_range %b, want %b", got.in_range, want.in_range));
      if (got.segment_hit !== want.segment_hit)
        report_mismatch($sformatf("segment_hit %0d, want %0d",
                                  got.segment_hit, want.segment_hit));
    endtask
  endclass

endpackage

@@ tb/sv/tb_piecewise_cubic_evaluator.sv @@
`timescale 1ns / 100ps
// Top-level testbench of piecewise_cubic_evaluator: directed and random loads/queries.
// Depends on pce_pkg, pce_if, the block itself and pce_tb_pkg.

module tb_piecewise_cubic_evaluator;

  localparam int PHASE_ITEMS = 95;
  localparam int DRAIN_CYCLES = 24;

  logic clk_i = 1'b0;
  logic rst_ni;
  bit   calm;

  always #6 clk_i = ~clk_i;

  pce_req_if req_bus ();
  pce_rsp_if rsp_bus ();
  pce_cfg_if cfg_bus ();

  piecewise_cubic_evaluator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  pce_tb_pkg::spline_table_model tables = new();

  // Result side: stalls at random except in calm stretches.
  always @(negedge clk_i) begin
    rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk_i) begin : take_point
    pce_tb_pkg::pce_point_t got;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      got.value_y = rsp_bus.value_y;
      got.in_range = rsp_bus.in_range;
      got.segment_hit = rsp_bus.segment_hit;
      tables.check_point(got);
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic signed [pce_pkg::C_W-1:0] random_coef();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
      2: return $signed(32'($urandom_range(0, 32'h2000))) - 32'sh1000;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0001_0000;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  // Fields a request does not use are filled with noise.
  function automatic pce_tb_pkg::pce_request_t load_item(int idx, int k,
                                                         logic signed [pce_pkg::C_W-1:0] a,
                                                         logic signed [pce_pkg::C_W-1:0] b,
                                                         logic signed [pce_pkg::C_W-1:0] c,
                                                         logic signed [pce_pkg::C_W-1:0] d);
    pce_tb_pkg::pce_request_t r;
    r.req_type = pce_pkg::REQ_LOAD;
    r.entry_index = idx[pce_pkg::IDX_W-1:0];
    r.knot_x = k[pce_pkg::X_W-1:0];
    r.coef_cubic = a;
    r.coef_square = b;
    r.coef_linear = c;
    r.coef_const = d;
    r.query_x = $urandom;
    return r;
  endfunction

  function automatic pce_tb_pkg::pce_request_t query_item(int q);
    pce_tb_pkg::pce_request_t r;
    r.req_type = pce_pkg::REQ_EVAL;
    r.entry_index = $urandom;
    r.knot_x = $urandom;
    r.coef_cubic = $urandom;
    r.coef_square = $urandom;
    r.coef_linear = $urandom;
    r.coef_const = $urandom;
    r.query_x = q[pce_pkg::X_W-1:0];
    return r;
  endfunction

  function automatic pce_tb_pkg::pce_request_t random_query(int n);
    int s;
    int lo;
    int hi;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 80 && n > 0) begin
      s = $urandom_range(0, n - 1);
      lo = tables.knots[s];
      hi = int'(tables.knots[s+1]) - 1;
      if (hi >= lo) return query_item(lo + int'($urandom_range(0, hi - lo)));
    end else if (pick < 90) begin
      s = $urandom_range(0, n);
      return query_item(int'(tables.knots[s]) - int'($urandom_range(0, 1)));
    end
    return query_item($urandom);
  endfunction

  function automatic pce_tb_pkg::pce_request_t random_load(int n);
    int i;
    int lo;
    int hi;
    int k;
    if ($urandom_range(0, 99) < 20)
      return load_item($urandom_range(0, 127), $urandom, random_coef(), random_coef(),
                       random_coef(), random_coef());
    // Reload that keeps the knots increasing.
    i = $urandom_range(0, n);
    lo = (i == 0) ? -8388608 : int'(tables.knots[i-1]) + 1;
    hi = (i == n) ? 8388607 : int'(tables.knots[i+1]) - 1;
    k = (hi >= lo) ? lo + int'($urandom_range(0, hi - lo)) : int'(tables.knots[i]);
    return load_item(i, k, random_coef(), random_coef(), random_coef(), random_coef());
  endfunction

  // Called just after a falling edge; leaves valid high, or low after a random pause.
  task automatic send_request(pce_tb_pkg::pce_request_t it);
    req_bus.req_type <= it.req_type;
    req_bus.entry_index <= it.entry_index;
    req_bus.knot_x <= it.knot_x;
    req_bus.coef_cubic <= it.coef_cubic;
    req_bus.coef_square <= it.coef_square;
    req_bus.coef_linear <= it.coef_linear;
    req_bus.coef_const <= it.coef_const;
    req_bus.query_x <= it.query_x;
    req_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!req_bus.ready);
    tables.note_request(it);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 99) < 22) begin
      req_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
  endtask

  // Loads give no result, so wait out the pipe once the last point is in.
  task automatic wait_for_drain();
    req_bus.valid <= 1'b0;
    while (tables.pending() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_segment_count(logic [pce_pkg::CNT_W-1:0] v);
    wait_for_drain();
    cfg_bus.data <= v;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_bus.ready);
    tables.set_segment_count(v);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Full table for n segments: knots spread over the whole axis or packed near zero.
  task automatic load_table(int n);
    bit wide;
    int base;
    int step;
    int k;
    wide = $urandom_range(0, 2) != 0;
    base = wide ? -8388608 : -131072;
    step = (wide ? (1 << 24) : (1 << 18)) / (n + 1);
    for (int i = 0; i <= n; i++) begin
      k = base + i * step + int'($urandom_range(0, step / 2));
      if (i == 0 && $urandom_range(0, 3) == 0) k = base;
      if (i == n && i > 0 && wide && $urandom_range(0, 3) == 0) k = 8388607;
      send_request(load_item(i, k, random_coef(), random_coef(), random_coef(),
                             random_coef()));
    end
  endtask

  task automatic run_directed();
    // count is 2 after reset
    send_request(load_item(0, -8388608, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
                           32'sh7fff_ffff));
    send_request(load_item(1, 0, 32'sh0001_0000, 32'sh0, 32'shfffe_0000, 32'sh0003_0000));
    // at the segment count: knot only, coefficients dropped
    send_request(load_item(2, 8388607, 32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff,
                           32'shffff_ffff));
    // beyond the knot store: ignored; index 64 sets only the last knot
    send_request(load_item(100, 0, 32'sh1, 32'sh1, 32'sh1, 32'sh1));
    send_request(load_item(127, 32'sh123456, 32'sh1, 32'sh1, 32'sh1, 32'sh1));
    send_request(load_item(64, 8388607, 32'sh2, 32'sh2, 32'sh2, 32'sh2));
    send_request(query_item(-8388608));
    send_request(query_item(-1));
    send_request(query_item(0));
    send_request(query_item(32'sh10000));
    send_request(query_item(1));
    send_request(query_item(8388606));
    send_request(query_item(8388607));
    // equal knots: first segment empty
    send_request(load_item(1, -8388608, 32'sh0, 32'sh0, 32'sh0, 32'sh0005_0000));
    send_request(query_item(-8388608));
    send_request(query_item(32'sh400000));
    // second segment empty
    send_request(load_item(1, 8388607, 32'sh0, 32'sh0, 32'sh0, 32'sh0005_0000));
    send_request(query_item(0));
    send_request(query_item(8388607));
    // query below the first knot
    send_request(load_item(0, 0, 32'sh0, 32'sh0, 32'sh0001_0000, 32'sh0));
    send_request(query_item(-5));
    send_request(query_item(32'sh7fff));
  endtask

  initial begin : stimulus
    logic [pce_pkg::CNT_W-1:0] count_plan [12];
    int                        n_eff;
    count_plan = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd9, 7'd65, 7'd17, 7'd2, 7'd40, 7'd64,
                   7'd33, 7'd1};
    count_plan[4] = $urandom_range(3, 63);
    count_plan[8] = $urandom_range(3, 63);
    calm = 1'b0;
    rst_ni = 1'b0;
    req_bus.valid = 1'b0;
    req_bus.req_type = pce_pkg::REQ_LOAD;
    req_bus.entry_index = '0;
    req_bus.knot_x = '0;
    req_bus.coef_cubic = '0;
    req_bus.coef_square = '0;
    req_bus.coef_linear = '0;
    req_bus.coef_const = '0;
    req_bus.query_x = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    rsp_bus.ready = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    run_directed();
    for (int p = 0; p < 12; p++) begin
      calm = (p == 3);
      write_segment_count(count_plan[p]);
      n_eff = tables.active_segments();
      load_table(n_eff);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 4 && k == PHASE_ITEMS / 2) wait_for_drain();
        if ($urandom_range(0, 99) < 70) begin
          send_request(random_query(n_eff));
        end else begin
          send_request(random_load(n_eff));
        end
      end
    end
    calm = 1'b0;
    wait_for_drain();
    if (tables.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
